@@ rtl/core/one_bit_scope_lcd_sequencer_top_defines.svh @@
// Assertion macros shared by the sequencer RTL.
`ifndef ONE_BIT_SCOPE_LCD_SEQUENCER_TOP_DEFINES_SVH
`define ONE_BIT_SCOPE_LCD_SEQUENCER_TOP_DEFINES_SVH

// Checks a property on every rising clock edge outside of reset.
`define OBSLCD_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Checks that a condition never holds.
`define OBSLCD_ASSERT_NEVER(label, expr, msg) \
  `OBSLCD_ASSERT(label, !(expr), msg)

`endif

@@ rtl/core/obslcd_pkg.sv @@
package obslcd_pkg;

  localparam int COLUMNS     = 40;
  localparam int LEVELS      = 7;
  localparam int COL_W       = 6;
  localparam int LEVEL_W     = 3;
  localparam int TICKS_W     = 17;
  localparam int UNIT_W      = 14;
  localparam int COUNT_W     = 30;
  localparam int PRODUCT_W   = 31;
  localparam int QUEUE_DEPTH = 2;
  localparam int QUEUE_PTR_W = $clog2(QUEUE_DEPTH);
  localparam int QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);

  localparam logic [TICKS_W-1:0] TICKS_RESET  = TICKS_W'(80000);
  localparam logic [LEVEL_W-1:0] LEVEL_RESET  = LEVEL_W'(5);
  localparam logic [COUNT_W-1:0] RELOAD_RESET = COUNT_W'(99999);

  localparam logic [1:0] OP_TICK   = 2'd0;
  localparam logic [1:0] OP_SLOWER = 2'd1;
  localparam logic [1:0] OP_FASTER = 2'd2;

  localparam logic [7:0] CMD_SHIFT   = 8'h18;
  localparam logic [7:0] ADDR_TOP    = 8'h80;
  localparam logic [7:0] ADDR_BOTTOM = 8'hC0;
  localparam logic [7:0] GLYPH_BLANK = 8'h20;
  localparam logic [7:0] GLYPH_RISE_TOP    = 8'h00;
  localparam logic [7:0] GLYPH_RISE_BOTTOM = 8'h01;
  localparam logic [7:0] GLYPH_HIGH_TOP    = 8'h02;
  localparam logic [7:0] GLYPH_FALL_TOP    = 8'h01;
  localparam logic [7:0] GLYPH_FALL_BOTTOM = 8'h03;
  localparam logic [7:0] GLYPH_LOW_BOTTOM  = 8'h04;

  typedef struct packed {
    logic [1:0] operation;
    logic       signal_level;
  } in_item_t;

  typedef struct packed {
    logic       register_select;
    logic [7:0] lcd_byte;
    logic       last;
  } out_item_t;

  // One expired sample, waiting to be drawn.
  typedef struct packed {
    logic             sample;
    logic             prior;
    logic [COL_W-1:0] col;
  } draw_t;

  typedef struct packed {
    logic full;
    logic empty;
  } queue_status_t;

  typedef enum logic [2:0] {
    STEP_TOP_ADDR,
    STEP_TOP_GLYPH,
    STEP_BOTTOM_ADDR,
    STEP_BOTTOM_GLYPH,
    STEP_SHIFT
  } step_e;

  // Sweep period in table units for each level.
  function automatic logic [UNIT_W-1:0] sweep_unit(input logic [LEVEL_W-1:0] level);
    logic [UNIT_W-1:0] unit;
    case (level)
      3'd0:    unit = UNIT_W'(2);
      3'd1:    unit = UNIT_W'(10);
      3'd2:    unit = UNIT_W'(50);
      3'd3:    unit = UNIT_W'(250);
      3'd4:    unit = UNIT_W'(750);
      3'd5:    unit = UNIT_W'(2500);
      default: unit = UNIT_W'(10000);
    endcase
    return unit;
  endfunction

endpackage

@@ rtl/core/obslcd_front.sv @@
`include "one_bit_scope_lcd_sequencer_top_defines.svh"

module obslcd_front (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              in_valid_i,
  output logic                              in_ready_o,
  input  obslcd_pkg::in_item_t              in_item_i,
  input  logic                              cfg_we_i,
  input  logic [obslcd_pkg::TICKS_W-1:0]    cfg_wdata_i,
  input  obslcd_pkg::queue_status_t         queue_status_i,
  output logic                              push_o,
  output obslcd_pkg::draw_t                 draw_o
);
  import obslcd_pkg::*;

  logic [TICKS_W-1:0]   ticks_q;
  logic [LEVEL_W-1:0]   level_q, level_d;
  logic [COUNT_W-1:0]   reload_q, reload_d;
  logic [COUNT_W-1:0]   count_q, count_d;
  logic                 prior_q, prior_d;
  logic [COL_W-1:0]     col_q, col_d;
  logic                 pending_q, pending_d;
  logic [PRODUCT_W-1:0] product_q, product_d;
  logic [PRODUCT_W-1:0] product_m1;
  logic [COUNT_W-1:0]   reload_sat;
  logic                 accept;

  // After a level change the registered product is turned into a reload value
  // while pending_q is set; no item is taken meanwhile.
  assign in_ready_o = !pending_q && !queue_status_i.full;
  assign accept     = in_valid_i && in_ready_o;

  assign product_m1 = product_q - PRODUCT_W'(1);
  always_comb begin
    if (product_q == '0) begin
      reload_sat = '0;
    end else if (product_m1[PRODUCT_W-1]) begin
      reload_sat = '1;
    end else begin
      reload_sat = product_m1[COUNT_W-1:0];
    end
  end

  always_comb begin
    level_d   = level_q;
    reload_d  = reload_q;
    count_d   = count_q;
    prior_d   = prior_q;
    col_d     = col_q;
    pending_d = 1'b0;
    product_d = product_q;
    push_o    = 1'b0;
    draw_o.sample = in_item_i.signal_level;
    draw_o.prior  = prior_q;
    draw_o.col    = col_q;
    if (pending_q) begin
      reload_d = reload_sat;
      count_d  = reload_sat;
    end
    if (accept) begin
      case (in_item_i.operation)
        OP_TICK: begin
          if (count_q == '0) begin
            count_d = reload_q;
            push_o  = 1'b1;
            prior_d = in_item_i.signal_level;
            col_d   = (col_q == COL_W'(COLUMNS - 1)) ? '0 : col_q + COL_W'(1);
          end else begin
            count_d = count_q - COUNT_W'(1);
          end
        end
        OP_SLOWER: begin
          if (level_q < LEVEL_W'(LEVELS - 1)) begin
            level_d   = level_q + LEVEL_W'(1);
            pending_d = 1'b1;
            product_d = PRODUCT_W'(sweep_unit(level_d)) * PRODUCT_W'(ticks_q);
          end
        end
        OP_FASTER: begin
          if (level_q != '0) begin
            level_d   = level_q - LEVEL_W'(1);
            pending_d = 1'b1;
            product_d = PRODUCT_W'(sweep_unit(level_d)) * PRODUCT_W'(ticks_q);
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ticks_q   <= TICKS_RESET;
      level_q   <= LEVEL_RESET;
      reload_q  <= RELOAD_RESET;
      count_q   <= RELOAD_RESET;
      prior_q   <= 1'b0;
      col_q     <= '0;
      pending_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        ticks_q <= cfg_wdata_i;
      end
      level_q   <= level_d;
      reload_q  <= reload_d;
      count_q   <= count_d;
      prior_q   <= prior_d;
      col_q     <= col_d;
      pending_q <= pending_d;
    end
  end

  always_ff @(posedge clk_i) begin
    product_q <= product_d;
  end

  `OBSLCD_ASSERT(a_pending_blocks_input, pending_q |-> !in_ready_o, "item taken during reload")
  `OBSLCD_ASSERT(a_level_in_range, level_q < LEVEL_W'(LEVELS), "sweep level out of range")

endmodule

@@ rtl/core/obslcd_queue.sv @@
`include "one_bit_scope_lcd_sequencer_top_defines.svh"

module obslcd_queue (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      push_i,
  input  obslcd_pkg::draw_t         draw_i,
  input  logic                      pop_i,
  output obslcd_pkg::draw_t         head_o,
  output obslcd_pkg::queue_status_t status_o
);
  import obslcd_pkg::*;

  draw_t                  entry_q [QUEUE_DEPTH];
  logic [QUEUE_PTR_W-1:0] wr_ptr_q, rd_ptr_q;
  logic [QUEUE_CNT_W-1:0] fill_q;

  assign head_o         = entry_q[rd_ptr_q];
  assign status_o.full  = (fill_q == QUEUE_CNT_W'(QUEUE_DEPTH));
  assign status_o.empty = (fill_q == '0);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      fill_q   <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= (wr_ptr_q == QUEUE_PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
      end
      if (pop_i) begin
        rd_ptr_q <= (rd_ptr_q == QUEUE_PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
      end
      if (push_i && !pop_i) begin
        fill_q <= fill_q + QUEUE_CNT_W'(1);
      end else if (pop_i && !push_i) begin
        fill_q <= fill_q - QUEUE_CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      entry_q[wr_ptr_q] <= draw_i;
    end
  end

  `OBSLCD_ASSERT_NEVER(a_no_overflow, push_i && status_o.full, "push into full queue")
  `OBSLCD_ASSERT_NEVER(a_no_underflow, pop_i && status_o.empty, "pop from empty queue")

endmodule

@@ rtl/core/obslcd_back.sv @@
`include "one_bit_scope_lcd_sequencer_top_defines.svh"

module obslcd_back (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  obslcd_pkg::draw_t         head_i,
  input  obslcd_pkg::queue_status_t queue_status_i,
  output logic                      pop_o,
  output logic                      out_valid_o,
  input  logic                      out_ready_i,
  output obslcd_pkg::out_item_t     out_item_o
);
  import obslcd_pkg::*;

  step_e      step_q, step_d;
  logic       advance;
  logic       out_valid_q, out_valid_d;
  out_item_t  out_q, out_d;
  logic [7:0] top_glyph, bottom_glyph, col_byte;

  assign advance = !queue_status_i.empty && (!out_valid_q || out_ready_i);
  assign pop_o   = advance && (step_q == STEP_SHIFT);
  assign col_byte = 8'(head_i.col);

  always_comb begin
    case ({head_i.sample, head_i.prior})
      2'b10:   begin top_glyph = GLYPH_RISE_TOP;  bottom_glyph = GLYPH_RISE_BOTTOM; end
      2'b11:   begin top_glyph = GLYPH_HIGH_TOP;  bottom_glyph = GLYPH_BLANK;       end
      2'b01:   begin top_glyph = GLYPH_FALL_TOP;  bottom_glyph = GLYPH_FALL_BOTTOM; end
      default: begin top_glyph = GLYPH_BLANK;     bottom_glyph = GLYPH_LOW_BOTTOM;  end
    endcase
  end

  // Next step of the five-write sequence.
  always_comb begin
    step_d = step_q;
    if (advance) begin
      case (step_q)
        STEP_TOP_ADDR:     step_d = STEP_TOP_GLYPH;
        STEP_TOP_GLYPH:    step_d = STEP_BOTTOM_ADDR;
        STEP_BOTTOM_ADDR:  step_d = STEP_BOTTOM_GLYPH;
        STEP_BOTTOM_GLYPH: step_d = STEP_SHIFT;
        default:           step_d = STEP_TOP_ADDR;
      endcase
    end
  end

  // Bus write for the current step.
  always_comb begin
    out_d       = out_q;
    out_valid_d = out_valid_q && !out_ready_i;
    if (advance) begin
      out_valid_d = 1'b1;
      case (step_q)
        STEP_TOP_ADDR:     out_d = '{1'b0, ADDR_TOP + col_byte, 1'b0};
        STEP_TOP_GLYPH:    out_d = '{1'b1, top_glyph, 1'b0};
        STEP_BOTTOM_ADDR:  out_d = '{1'b0, ADDR_BOTTOM + col_byte, 1'b0};
        STEP_BOTTOM_GLYPH: out_d = '{1'b1, bottom_glyph, 1'b0};
        default:           out_d = '{1'b0, CMD_SHIFT, 1'b1};
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q      <= STEP_TOP_ADDR;
      out_valid_q <= 1'b0;
    end else begin
      step_q      <= step_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q <= out_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

  `OBSLCD_ASSERT(a_last_ends_sequence, (out_valid_q && out_q.last) |-> (step_q == STEP_TOP_ADDR), "last write out of step")

endmodule

@@ rtl/core/one_bit_scope_lcd_sequencer_top.sv @@
// One-bit scope LCD sequencer.
// The input channel (in_valid_i / in_ready_o / in_item_i) takes one item per
// prescaled timer tick or per slower/faster request. A tick that finds the
// countdown at zero samples signal_level and produces five LCD bus writes on
// the output channel (out_valid_o / out_ready_i / out_item_o): top-row address,
// top glyph, bottom-row address, bottom glyph and the display shift command,
// the last one flagged by last. All other items produce nothing.
// An item is normally taken every cycle; a level change holds off the next
// one while the registered product of the sweep multiplier becomes the reload
// value. The first write of a sample passes through the queue and the output
// register; the five writes then go out at one per cycle while the receiver
// is ready, and the next sample leaves the queue with the shift write.
// A two-entry queue sits between the front and the back end; when it is full
// the input stalls, and a stalled receiver holds the current write in place.
// The ticks_per_unit register is written through cfg_we_i / cfg_wdata_i and
// should only change while the block is idle.
// Reset restores sweep level 5, a reload value and countdown of 99999,
// ticks_per_unit 80000, column 0 and an empty queue.
module one_bit_scope_lcd_sequencer_top (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           in_valid_i,
  output logic                           in_ready_o,
  input  obslcd_pkg::in_item_t           in_item_i,
  output logic                           out_valid_o,
  input  logic                           out_ready_i,
  output obslcd_pkg::out_item_t          out_item_o,
  input  logic                           cfg_we_i,
  input  logic [obslcd_pkg::TICKS_W-1:0] cfg_wdata_i
);
  import obslcd_pkg::*;

  queue_status_t queue_status;
  logic          push;
  logic          pop;
  draw_t         draw_in;
  draw_t         draw_head;

  // Front: handles the countdown, the sweep level and the sample history.
  obslcd_front u_front (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .in_item_i      (in_item_i),
    .cfg_we_i       (cfg_we_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .queue_status_i (queue_status),
    .push_o         (push),
    .draw_o         (draw_in)
  );

  // Queue of expired samples still to be drawn.
  obslcd_queue u_queue (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .push_i   (push),
    .draw_i   (draw_in),
    .pop_i    (pop),
    .head_o   (draw_head),
    .status_o (queue_status)
  );

  // Back end: turns each sample into its five bus writes.
  obslcd_back u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .head_i         (draw_head),
    .queue_status_i (queue_status),
    .pop_o          (pop),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .out_item_o     (out_item_o)
  );

endmodule

@@ bench/tb_top.sv @@
`timescale 1ns / 100ps

// Bench for the one-bit scope LCD sequencer.
//
// The stimulus walks through several ticks_per_unit settings. Each setting is
// written while the block is idle, and a level change then loads the countdown
// from it. Small settings keep the sweep period short, so that most timer
// ticks soon end in a sample and five LCD writes. A scoreboard class keeps its
// own copy of the sweep level, countdown, prior sample and column. It turns
// every accepted input item into the LCD writes that item should cause, and it
// checks each write that the block hands out against the oldest one waiting.
module tb_top;
  import obslcd_pkg::*;

  // Operation code that the block must ignore.
  localparam logic [1:0] OP_UNUSED = 2'd3;

  localparam int WATCHDOG_LIMIT = 2000;
  // Margin after the last expected write, so that a level change still holding
  // the front busy and any other work in flight can finish.
  localparam int SETTLE_CYCLES = 8;
  // Random level changes stay where the reload value, one less than the ticks
  // in a sweep period, is at most this, so that samples keep coming.
  localparam int CHEAP_RELOAD = 255;
  localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

  class trace_board;
    logic [TICKS_W-1:0] ticks_per_unit;
    logic [LEVEL_W-1:0] level;
    logic [COUNT_W-1:0] reload;
    logic [COUNT_W-1:0] countdown;
    logic               prior;
    logic [COL_W-1:0]   column;
    out_item_t          pending_writes[$];
    int                 errors;
    int                 writes_checked;
    int                 columns_drawn;
    int                 wraps;
    int                 bound_requests;

    function new();
      ticks_per_unit = TICKS_RESET;
      level          = LEVEL_RESET;
      reload         = RELOAD_RESET;
      countdown      = RELOAD_RESET;
      prior          = 1'b0;
      column         = '0;
      errors         = 0;
      writes_checked = 0;
      columns_drawn  = 0;
      wraps          = 0;
      bound_requests = 0;
    endfunction

    // Reload value that a change to the given level would load.
    function logic [COUNT_W-1:0] reload_for(logic [LEVEL_W-1:0] lvl);
      int unsigned unit;
      logic [47:0] product;
      case (lvl)
        3'd0:    unit = 2;
        3'd1:    unit = 10;
        3'd2:    unit = 50;
        3'd3:    unit = 250;
        3'd4:    unit = 750;
        3'd5:    unit = 2500;
        default: unit = 10000;
      endcase
      product = 48'(unit) * 48'(ticks_per_unit);
      if (product == 0) return '0;
      if (product - 1 > 48'(COUNT_MAX)) return COUNT_MAX;
      return COUNT_W'(product - 1);
    endfunction

    function void note_item(in_item_t it);
      logic [7:0]       top;
      logic [7:0]       bottom;
      logic [COL_W-1:0] col;
      case (it.operation)
        OP_SLOWER: begin
          if (level < LEVELS - 1) begin
            level     = level + 1'b1;
            reload    = reload_for(level);
            countdown = reload;
          end else begin
            bound_requests++;
          end
        end
        OP_FASTER: begin
          if (level > 0) begin
            level     = level - 1'b1;
            reload    = reload_for(level);
            countdown = reload;
          end else begin
            bound_requests++;
          end
        end
        OP_TICK: begin
          if (countdown != 0) begin
            countdown = countdown - 1'b1;
          end else begin
            countdown = reload;
            case ({it.signal_level, prior})
              2'b10: begin
                top    = GLYPH_RISE_TOP;
                bottom = GLYPH_RISE_BOTTOM;
              end
              2'b11: begin
                top    = GLYPH_HIGH_TOP;
                bottom = GLYPH_BLANK;
              end
              2'b01: begin
                top    = GLYPH_FALL_TOP;
                bottom = GLYPH_FALL_BOTTOM;
              end
              default: begin
                top    = GLYPH_BLANK;
                bottom = GLYPH_LOW_BOTTOM;
              end
            endcase
            col = COL_W'(column % COLUMNS);
            pending_writes.push_back(out_item_t'{register_select: 1'b0,
                                                 lcd_byte: ADDR_TOP + 8'(col), last: 1'b0});
            pending_writes.push_back(out_item_t'{register_select: 1'b1,
                                                 lcd_byte: top, last: 1'b0});
            pending_writes.push_back(out_item_t'{register_select: 1'b0,
                                                 lcd_byte: ADDR_BOTTOM + 8'(col), last: 1'b0});
            pending_writes.push_back(out_item_t'{register_select: 1'b1,
                                                 lcd_byte: bottom, last: 1'b0});
            pending_writes.push_back(out_item_t'{register_select: 1'b0,
                                                 lcd_byte: CMD_SHIFT, last: 1'b1});
            prior  = it.signal_level;
            column = COL_W'((col + 1) % COLUMNS);
            columns_drawn++;
            if (column == 0) wraps++;
          end
        end
        default: ;
      endcase
    endfunction

    function void compare(string field, int unsigned want, int unsigned got);
      if (want != got) begin
        errors++;
        $display("%0t: %s mismatch, expected 0x%0h, actual 0x%0h", $time, field, want, got);
      end
    endfunction

    function void check_write(out_item_t got);
      out_item_t want;
      writes_checked++;
      if (pending_writes.size() == 0) begin
        errors++;
        $display("%0t: unexpected LCD write, expected none, actual rs=%0b byte=0x%02h last=%0b",
                 $time, got.register_select, got.lcd_byte, got.last);
        return;
      end
      want = pending_writes.pop_front();
      compare("register_select", want.register_select, got.register_select);
      compare("lcd_byte", want.lcd_byte, got.lcd_byte);
      compare("last", want.last, got.last);
    endfunction
  endclass

  logic               clk_i;
  logic               rst_ni    = 1'b0;
  logic               in_valid  = 1'b0;
  logic               in_ready;
  in_item_t           in_item   = '0;
  logic               out_valid;
  logic               out_ready = 1'b1;
  out_item_t          out_item;
  logic               cfg_we    = 1'b0;
  logic [TICKS_W-1:0] cfg_wdata = '0;

  trace_board board;
  // Random idling on both channels is allowed only while this is set.
  bit idle_on = 1'b1;
  int items_sent = 0;
  int settings_used = 0;
  int stall_left = 0;
  int quiet_cycles = 0;

  one_bit_scope_lcd_sequencer_top DUT (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready),
    .in_item_i   (in_item),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .out_item_o  (out_item),
    .cfg_we_i    (cfg_we),
    .cfg_wdata_i (cfg_wdata)
  );

  always begin
    clk_i = 1'b0;
    #4;
    clk_i = 1'b1;
    #4;
  end

  // The receiver drops ready for random bursts while idling is allowed. A
  // burst that has started always runs to its end.
  always @(posedge clk_i) begin
    if (stall_left > 0) begin
      stall_left--;
      if (stall_left == 0) out_ready <= 1'b1;
    end else if (rst_ni && idle_on && $urandom_range(0, 9) == 0) begin
      stall_left = $urandom_range(1, 18);
      out_ready <= 1'b0;
    end
  end

  // Every accepted LCD write is checked here. The watchdog ends the run once
  // neither channel has moved an item for too long.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_valid && out_ready) board.check_write(out_item);
      if ((in_valid && in_ready) || (out_valid && out_ready)) quiet_cycles = 0;
      else quiet_cycles++;
      if (quiet_cycles == WATCHDOG_LIMIT) begin
        $display("%0t: no item moved on either channel for %0d cycles", $time, WATCHDOG_LIMIT);
        $display("CHECKS FAILED");
        $finish;
      end
    end
  end

  // Offers one item and returns at the edge where it is taken. Valid stays
  // high between back-to-back items; a random gap lowers it first.
  task automatic send_op(logic [1:0] op, logic sig);
    in_item_t it;
    it.operation    = op;
    it.signal_level = sig;
    if (idle_on && $urandom_range(0, 4) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 18)) @(posedge clk_i);
    end
    in_item  <= it;
    in_valid <= 1'b1;
    do @(posedge clk_i); while (!in_ready);
    board.note_item(it);
    if (op != OP_UNUSED) items_sent++;
  endtask

  // Holds the sender back until every expected write has been seen, then
  // gives the block time to finish any level change still in progress.
  task automatic drain();
    in_valid <= 1'b0;
    do @(posedge clk_i); while (board.pending_writes.size() != 0);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_ticks(logic [TICKS_W-1:0] value);
    drain();
    cfg_we    <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk_i);
    cfg_we <= 1'b0;
    board.ticks_per_unit = value;
    settings_used++;
  endtask

  // Mostly timer ticks with random signal bits, mixed with level changes that
  // keep the sweep period short, requests at either bound and the unused code.
  // A fresh setting leaves the old countdown in place, so the phase first
  // steps the level down until the countdown is short again. Halfway through,
  // the sender waits until all expected writes have come out.
  task automatic random_phase(logic [TICKS_W-1:0] tpu, int count, bit idles);
    int          sent;
    int unsigned roll;
    logic [1:0]  op;
    write_ticks(tpu);
    idle_on = idles;
    sent = 0;
    while (sent < count) begin
      roll = $urandom_range(0, 99);
      if (board.countdown > CHEAP_RELOAD && board.level != 0) begin
        op = OP_FASTER;
      end else if (roll < 4) begin
        op = OP_UNUSED;
      end else if (roll < 14 && (board.level == LEVELS - 1 ||
                   board.reload_for(LEVEL_W'(board.level + 1)) <= CHEAP_RELOAD)) begin
        op = OP_SLOWER;
      end else if (roll < 24) begin
        op = OP_FASTER;
      end else begin
        op = OP_TICK;
      end
      if (sent == count / 2 && op != OP_UNUSED) drain();
      send_op(op, 1'($urandom_range(0, 1)));
      if (op != OP_UNUSED) sent++;
    end
  endtask

  // With the largest setting the top level saturates the reload value. No
  // sample can be reached here; the later phases step back down from it.
  task automatic saturation_phase();
    write_ticks('1);
    while (board.level != LEVELS - 1) send_op(OP_SLOWER, 1'($urandom_range(0, 1)));
    send_op(OP_SLOWER, 1'b1);
    send_op(OP_TICK, 1'b1);
    send_op(OP_TICK, 1'b0);
    send_op(OP_FASTER, 1'b0);
    send_op(OP_SLOWER, 1'b1);
  endtask

  initial begin
    board = new();
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Reset values: the tick only counts down, the unused code is ignored,
    // and the level walks up to its top, once past it, then all the way down
    // and once below the bottom.
    send_op(OP_TICK, 1'b1);
    send_op(OP_UNUSED, 1'b1);
    send_op(OP_SLOWER, 1'b0);
    send_op(OP_SLOWER, 1'b1);
    send_op(OP_TICK, 1'b0);
    for (int i = 0; i < LEVELS - 1; i++) send_op(OP_FASTER, 1'(i));
    send_op(OP_FASTER, 1'b1);

    // With one tick per unit the bottom level samples every second tick. The
    // samples go high, stay high, fall and stay low, covering all four glyphs.
    write_ticks(TICKS_W'(1));
    send_op(OP_SLOWER, 1'b0);
    send_op(OP_FASTER, 1'b1);
    send_op(OP_TICK, 1'b0);
    send_op(OP_TICK, 1'b1);
    send_op(OP_TICK, 1'b0);
    send_op(OP_TICK, 1'b1);
    send_op(OP_TICK, 1'b1);
    send_op(OP_TICK, 1'b0);
    send_op(OP_TICK, 1'b1);
    send_op(OP_TICK, 1'b0);

    // A zero setting makes every tick a sample, which keeps the output side
    // busy and fills the queue. The stretch with setting 3 and the final
    // stretch run without any idling.
    random_phase(TICKS_W'(1), 80, 1'b1);
    random_phase(TICKS_W'(0), 70, 1'b1);
    saturation_phase();
    random_phase(TICKS_W'(2), 70, 1'b1);
    random_phase(TICKS_W'(3), 60, 1'b0);
    random_phase(TICKS_W'(1), 60, 1'b1);
    random_phase(TICKS_W'(5), 60, 1'b0);
    drain();

    $display("Sent %0d items over %0d ticks_per_unit settings, zero and the 17-bit top among them.",
             items_sent, settings_used);
    $display("Checked %0d LCD writes: %0d columns, %0d wraps, %0d requests at a level bound.",
             board.writes_checked, board.columns_drawn, board.wraps, board.bound_requests);
    if (board.pending_writes.size() != 0)
      $display("%0t: %0d expected LCD writes never came out", $time, board.pending_writes.size());
    if (board.errors == 0 && board.pending_writes.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
